### hw/rtl/subtractive_lagged_prng_assert.svh
// Assertion macros shared by the generator's modules.
// Each expects clk and the active-low rst_n in scope.
`ifndef SUBTRACTIVE_LAGGED_PRNG_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_PRNG_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slp_pkg.sv
`default_nettype none

package slp_pkg;

  localparam int TABLE_ENTRIES = 56;

  typedef logic [5:0] tbl_addr_t;

  localparam logic [31:0] MBIG     = 32'h7FFF_FFFF;
  localparam logic [31:0] MSEED    = 32'd161803398;
  localparam logic [31:0] SEED_MIN = 32'h8000_0000;

  // Scheme constants: long lag, short lag, last fill index, conditioning partner split and offsets, last pass.
  localparam tbl_addr_t LAG_LONG      = 6'd55;
  localparam tbl_addr_t LAG_SHORT     = 6'd21;
  localparam tbl_addr_t FILL_LAST     = 6'd54;
  localparam tbl_addr_t PARTNER_SPLIT = 6'd24;
  localparam tbl_addr_t PARTNER_UP    = 6'd31;
  localparam tbl_addr_t PARTNER_DOWN  = 6'd24;
  localparam logic [1:0] LAST_PASS    = 2'd3;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_LOW_ABOVE_HIGH = 2'd1,
    ST_TOO_WIDE       = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_CAPTURE  = 4'd1,
    OP_SEED     = 4'd2,
    OP_FILL     = 4'd3,
    OP_MIX_RD   = 4'd4,
    OP_MIX_WR   = 4'd5,
    OP_DRAW     = 4'd6,
    OP_MUL      = 4'd7,
    OP_DIV      = 4'd8,
    OP_LOAD_OUT = 4'd9
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    tbl_addr_t idx;
  } dp_cmd_t;

  // Pull a negative word back by adding MBIG once.
  function automatic logic [31:0] fold(input logic [31:0] x);
    fold = x[31] ? (x + MBIG) : x;
  endfunction

  // Advance a ring pointer through 1..TABLE_ENTRIES-1.
  function automatic tbl_addr_t next_ptr(input tbl_addr_t p);
    tbl_addr_t n;
    n = p + 6'd1;
    next_ptr = (n >= tbl_addr_t'(TABLE_ENTRIES)) ? 6'd1 : n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/slp_ctrl.sv
`default_nettype none

module slp_ctrl import slp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_command,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_SEED   = 9'b0_0000_0010,
    S_FILL   = 9'b0_0000_0100,
    S_MIX_RD = 9'b0_0000_1000,
    S_MIX_WR = 9'b0_0001_0000,
    S_WB     = 9'b0_0010_0000,
    S_MUL    = 9'b0_0100_0000,
    S_DIV    = 9'b0_1000_0000,
    S_FIN    = 9'b1_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  tbl_addr_t  idx_r, idx_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;
  logic       mix_last;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign mix_last  = (idx_r == LAG_LONG) && (pass_r == LAST_PASS);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = (in_command == CMD_DRAW) ? S_WB : S_SEED;
        end
      end
      S_SEED: begin
        cmd.op    = OP_SEED;
        idx_nxt   = 6'd1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (idx_r == FILL_LAST) begin
          idx_nxt   = 6'd1;
          pass_nxt  = '0;
          state_nxt = S_MIX_RD;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      S_MIX_RD: begin
        cmd.op    = OP_MIX_RD;
        state_nxt = S_MIX_WR;
      end
      S_MIX_WR: begin
        cmd.op    = OP_MIX_WR;
        state_nxt = S_MIX_RD;
        if (idx_r == LAG_LONG) begin
          idx_nxt = 6'd1;
          if (pass_r == LAST_PASS) begin
            state_nxt = S_FIN;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      S_WB: begin
        cmd.op    = OP_DRAW;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the finished word until the output register frees up
        if (out_free) begin
          cmd.op    = OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == OP_LOAD_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "subtractive_lagged_prng_assert.svh"

  `SLP_ASSERT_NEXT(a_draw_to_wb, accept && in_command == CMD_DRAW, state_r == S_WB, "no write-back")
  `SLP_ASSERT_NEXT(a_mix_end, state_r == S_MIX_WR && mix_last, state_r == S_FIN, "init overran")
  `SLP_ASSERT_NEXT(a_fin_loads, cmd.op == OP_LOAD_OUT, out_valid_r && in_ready, "word not loaded")

endmodule

`default_nettype wire

### hw/rtl/slp_dp.sv
`default_nettype none

module slp_dp import slp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  input  wire logic               in_command,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [31:0] cfg_wr_data,
  output logic signed [31:0]      out_ranged_value,
  output logic        [30:0]      out_raw_sample,
  output logic        [1:0]       out_status
);

  logic [31:0] mem [TABLE_ENTRIES];

  logic [31:0] seed_r;
  logic        loaded_r;
  tbl_addr_t   lead_r, trail_r;
  logic [31:0] rd0_r, rd1_r;
  logic [31:0] mj_r, mk_r;
  tbl_addr_t   fill_addr_r;
  logic [31:0] lo_r;
  logic [30:0] range_r;
  status_t     stat_r;
  logic        init_r;
  logic [30:0] sample_r;
  logic [61:0] prod_r;
  logic [30:0] quot_r;
  logic [31:0] res_value_r;
  logic [30:0] res_sample_r;
  status_t     res_status_r;

  tbl_addr_t   ptr_a, ptr_b, partner, ra0, ra1, wa;
  logic        we;
  logic [31:0] wd;
  logic [31:0] rd0, rd1, sub, draw_val, mix_val, mag, seed_word;
  logic [32:0] span;
  status_t     span_stat;
  logic [6:0]  fill_sum;
  tbl_addr_t   fill_next;
  logic [62:0] div_sum;

  assign ptr_a   = next_ptr(lead_r);
  assign ptr_b   = next_ptr(trail_r);
  assign partner = (cmd.idx <= PARTNER_SPLIT) ? (cmd.idx + PARTNER_UP)
                                               : (cmd.idx - PARTNER_DOWN);
  assign ra0 = (cmd.op == OP_MIX_RD) ? cmd.idx : ptr_a;
  assign ra1 = (cmd.op == OP_MIX_RD) ? partner : ptr_b;

  // an untouched table reads as zero until the first seeding
  assign rd0 = loaded_r ? rd0_r : '0;
  assign rd1 = loaded_r ? rd1_r : '0;
  assign sub = rd0 - rd1;

  always_comb begin
    draw_val = (sub == MBIG) ? (MBIG - 32'd1) : sub;
    draw_val = fold(fold(draw_val));
  end
  assign mix_val = fold(sub);

  always_comb begin
    if (seed_r == SEED_MIN) begin
      mag = MBIG;
    end else if (seed_r[31]) begin
      mag = 32'd0 - seed_r;
    end else begin
      mag = seed_r;
    end
  end
  assign seed_word = MSEED - mag;

  assign fill_sum  = {1'b0, fill_addr_r} + {1'b0, LAG_SHORT};
  assign fill_next = (fill_sum >= {1'b0, LAG_LONG}) ? tbl_addr_t'(fill_sum - {1'b0, LAG_LONG})
                                                    : fill_sum[5:0];

  assign span = {in_range_high[31], in_range_high} - {in_range_low[31], in_range_low};
  always_comb begin
    if (span[32]) begin
      span_stat = ST_LOW_ABOVE_HIGH;
    end else if (span[31]) begin
      span_stat = ST_TOO_WIDE;
    end else begin
      span_stat = ST_OK;
    end
  end

  // floor(p / (2^31-1)) = (p + (p >> 31) + 1) >> 31 while the quotient stays below 2^31
  assign div_sum = {1'b0, prod_r} + {32'd0, prod_r[61:31]} + 63'd1;

  always_comb begin
    we = 1'b0;
    wa = ptr_a;
    wd = draw_val;
    unique case (cmd.op)
      OP_SEED: begin
        we = 1'b1;
        wa = LAG_LONG;
        wd = seed_word;
      end
      OP_FILL: begin
        we = 1'b1;
        wa = fill_addr_r;
        wd = mk_r;
      end
      OP_MIX_WR: begin
        we = 1'b1;
        wa = cmd.idx;
        wd = mix_val;
      end
      OP_DRAW: begin
        we = (stat_r == ST_OK);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      loaded_r <= 1'b0;
      lead_r   <= '0;
      trail_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (cmd.op == OP_SEED) begin
        loaded_r <= 1'b1;
      end
      if ((cmd.op == OP_DRAW) && (stat_r == ST_OK)) begin
        lead_r  <= ptr_a;
        trail_r <= ptr_b;
      end else if ((cmd.op == OP_LOAD_OUT) && init_r) begin
        lead_r  <= '0;
        trail_r <= LAG_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        init_r  <= (in_command == CMD_INIT);
        lo_r    <= in_range_low;
        range_r <= span[30:0];
        stat_r  <= span_stat;
      end
      OP_SEED: begin
        mj_r        <= seed_word;
        mk_r        <= 32'd1;
        fill_addr_r <= LAG_SHORT;
      end
      OP_FILL: begin
        mk_r        <= fold(mj_r - mk_r);
        mj_r        <= mk_r;
        fill_addr_r <= fill_next;
      end
      OP_DRAW: begin
        sample_r <= (stat_r == ST_OK) ? draw_val[30:0] : '0;
      end
      OP_MUL: begin
        prod_r <= {31'd0, sample_r} * {31'd0, range_r};
      end
      OP_DIV: begin
        quot_r <= div_sum[61:31];
      end
      OP_LOAD_OUT: begin
        if (init_r) begin
          res_value_r  <= '0;
          res_sample_r <= '0;
          res_status_r <= ST_OK;
        end else if (stat_r != ST_OK) begin
          res_value_r  <= '1;
          res_sample_r <= '0;
          res_status_r <= stat_r;
        end else begin
          res_value_r  <= lo_r + {1'b0, quot_r};
          res_sample_r <= sample_r;
          res_status_r <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ranged_value = res_value_r;
  assign out_raw_sample   = res_sample_r;
  assign out_status       = res_status_r;

`include "subtractive_lagged_prng_assert.svh"

  `SLP_ASSERT_NEXT(a_seed_loads, cmd.op == OP_SEED, loaded_r, "seeding left table unloaded")
  `SLP_ASSERT_SAME(a_err_word, cmd.op == OP_DRAW && stat_r != ST_OK, !we, "rejected draw wrote")
  `SLP_ASSERT_NEXT(a_sample_range, cmd.op == OP_DRAW, sample_r != MBIG[30:0], "sample hit 2^31-1")

endmodule

`default_nettype wire

### hw/rtl/subtractive_lagged_prng.sv
// Subtractive lagged random generator with a 55-word lag table.
// Input channel (in_valid/in_ready): in_command 0 seeds the table from the seed
// register, in_command 1 draws one sample and scales it into
// [in_range_low, in_range_high). Each accepted word yields exactly one result
// word on the output channel (out_valid/out_ready): out_ranged_value,
// out_raw_sample and out_status (0 ok, 1 low above high, 2 span too wide).
// The user must write the seed register through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this.
// Draw: table read with write-back, one multiply stage, one reciprocal-division
// stage, then the result load; the next word is accepted only after that load.
// Init: the seed word and the fill, then the conditioning passes do 220
// read/write pairs on the single-write table memory.
// Reset clears the seed, pointers and an epoch flag so that the table reads as
// all zero until the first init; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// block takes one more input word, then waits with its next result until the
// output register is freed.
`default_nettype none

module subtractive_lagged_prng import slp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [31:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_ranged_value,
  output logic        [30:0]      out_raw_sample,
  output logic        [1:0]       out_status
);

  dp_cmd_t cmd;

  // sequence the init walk and the draw stages
  slp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  // table memory, pointers, arithmetic and the output register
  slp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_command),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_ranged_value (out_ranged_value),
    .out_raw_sample   (out_raw_sample),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire
